// ===== rtl/core/chwm_pkg.sv =====
// Shared constants, types and helpers for the certificate hostname wildcard matcher.
package chwm_pkg;

  localparam int MAX_LEN     = 256;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CHAR_W      = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] FOLD_OFS = 8'h20;

  localparam logic [1:0] DOT_SAT = 2'd2;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_HOST    = 1'b1;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              none;
    logic              is_lit;
    logic              is_star;
    logic              is_dot;
  } chwm_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_COMPARE,
    ST_FINISH
  } chwm_state_t;

  function automatic logic is_literal(input logic [CHAR_W-1:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
  endfunction

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? (c + FOLD_OFS) : c;
  endfunction

endpackage

// ===== rtl/core/chwm_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the matcher.
interface chwm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  logic       last_char;
  logic       no_char;

  modport source (output valid, action, char_code, last_char, no_char, input ready);
  modport sink   (input valid, action, char_code, last_char, no_char, output ready);
endinterface

interface chwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic too_long;

  modport source (output valid, matched, too_long, input ready);
  modport sink   (input valid, matched, too_long, output ready);
endinterface

// ===== rtl/core/chwm_front.sv =====
// Front end: takes requests and classifies each character for the back end.
module chwm_front (
  chwm_in_if.sink              in_ch,
  output logic                 push_valid,
  output chwm_pkg::chwm_entry_t push_entry,
  input  logic                 push_ready
);
  import chwm_pkg::*;

  always_comb begin
    push_entry.action  = in_ch.action;
    push_entry.ch      = fold_case(in_ch.char_code);
    push_entry.last    = in_ch.last_char;
    push_entry.none    = in_ch.no_char;
    push_entry.is_lit  = is_literal(in_ch.char_code);
    push_entry.is_star = (in_ch.char_code == CH_STAR);
    push_entry.is_dot  = (in_ch.char_code == CH_DOT);
    push_valid         = in_ch.valid;
    in_ch.ready        = push_ready;
  end

endmodule

// ===== rtl/core/chwm_queue.sv =====
// Short queue of classified requests between the front and back ends.
module chwm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  chwm_pkg::chwm_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output chwm_pkg::chwm_entry_t pop_entry,
  input  logic                  pop_ready
);
  import chwm_pkg::*;

  chwm_entry_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  always_comb begin
    push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
    pop_valid  = (cnt_r != '0);
    pop_entry  = slot_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/chwm_back.sv =====
// Back end: stores both strings, runs the match sequence and holds the result.
module chwm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  chwm_pkg::chwm_entry_t pop_entry,
  output logic                  pop_ready,
  chwm_out_if.source            out_ch
);
  import chwm_pkg::*;

  logic [CHAR_W-1:0] pat_mem  [MAX_LEN];
  logic [CHAR_W-1:0] host_mem [MAX_LEN];
  logic [CHAR_W-1:0] pat_rd_r, host_rd_r;

  chwm_state_t state_r, state_nxt;

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] hlen_r, hlen_nxt;
  logic             pnum_r, pnum_nxt;
  logic             hnum_r, hnum_nxt;
  logic [1:0]       dots_r, dots_nxt;
  logic             ovf_r, ovf_nxt;
  logic             p0star_r, p0star_nxt;
  logic             p1dot_r, p1dot_nxt;
  logic             ps_r, ps_nxt;
  logic [LEN_W-1:0] hs_r, hs_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             mismatch_r, mismatch_nxt;
  logic             toolong_r, toolong_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic             out_toolong_r, out_toolong_nxt;

  logic              pat_we, host_we, rd_en;
  logic [ADDR_W-1:0] pat_waddr, host_waddr, pat_raddr, host_raddr;
  logic [LEN_W-1:0]  rest, hs_calc, n_calc, hspan, p_sum, h_sum;
  logic              wild;

  always_comb begin
    state_nxt       = state_r;
    plen_nxt        = plen_r;
    hlen_nxt        = hlen_r;
    pnum_nxt        = pnum_r;
    hnum_nxt        = hnum_r;
    dots_nxt        = dots_r;
    ovf_nxt         = ovf_r;
    p0star_nxt      = p0star_r;
    p1dot_nxt       = p1dot_r;
    ps_nxt          = ps_r;
    hs_nxt          = hs_r;
    n_nxt           = n_r;
    cnt_nxt         = cnt_r;
    rd_pend_nxt     = 1'b0;
    mismatch_nxt    = mismatch_r;
    toolong_nxt     = toolong_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    out_toolong_nxt = out_toolong_r;
    pop_ready       = 1'b0;
    pat_we          = 1'b0;
    host_we         = 1'b0;
    rd_en           = 1'b0;
    pat_waddr       = plen_r[ADDR_W-1:0];
    host_waddr      = hlen_r[ADDR_W-1:0];

    // Wildcard decision terms, used in the decide step.
    wild    = !pnum_r && !hnum_r && (plen_r >= LEN_W'(2)) && p0star_r && p1dot_r;
    rest    = plen_r - 1'b1;
    hs_calc = (wild && (dots_r == DOT_SAT) && (hlen_r > rest)) ? (hlen_r - rest) : '0;
    n_calc  = plen_r - {{(LEN_W-1){1'b0}}, wild};
    hspan   = hlen_r - hs_calc;

    p_sum      = {{(LEN_W-1){1'b0}}, ps_r} + cnt_r;
    h_sum      = hs_r + cnt_r;
    pat_raddr  = p_sum[ADDR_W-1:0];
    host_raddr = h_sum[ADDR_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Compare the pair read in the previous cycle.
    if (rd_pend_r && (pat_rd_r != host_rd_r)) begin
      mismatch_nxt = 1'b1;
    end

    case (state_r)
      ST_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (!pop_entry.none) begin
            if (pop_entry.action == ACT_PATTERN) begin
              if (plen_r == LEN_W'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                if (!((plen_r == '0) && pop_entry.is_star) && !pop_entry.is_lit) begin
                  pnum_nxt = 1'b0;
                end
                if ((plen_r != '0) && pop_entry.is_dot && (dots_r != DOT_SAT)) begin
                  dots_nxt = dots_r + 1'b1;
                end
                if (plen_r == LEN_W'(0)) begin
                  p0star_nxt = pop_entry.is_star;
                end
                if (plen_r == LEN_W'(1)) begin
                  p1dot_nxt = pop_entry.is_dot;
                end
                pat_we   = 1'b1;
                plen_nxt = plen_r + 1'b1;
              end
            end else begin
              if (hlen_r == LEN_W'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                if (!pop_entry.is_lit) begin
                  hnum_nxt = 1'b0;
                end
                host_we  = 1'b1;
                hlen_nxt = hlen_r + 1'b1;
              end
            end
          end
          if ((pop_entry.action == ACT_HOST) && pop_entry.last) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        toolong_nxt  = ovf_r;
        mismatch_nxt = 1'b0;
        ps_nxt       = wild;
        hs_nxt       = hs_calc;
        n_nxt        = n_calc;
        cnt_nxt      = '0;
        if (ovf_r || (plen_r == '0) || (n_calc != hspan)) begin
          mismatch_nxt = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          state_nxt = ST_COMPARE;
        end
      end

      ST_COMPARE: begin
        if (cnt_r != n_r) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = !mismatch_r && !toolong_r;
          out_toolong_nxt = toolong_r;
          plen_nxt        = '0;
          hlen_nxt        = '0;
          pnum_nxt        = 1'b1;
          hnum_nxt        = 1'b1;
          dots_nxt        = '0;
          ovf_nxt         = 1'b0;
          p0star_nxt      = 1'b0;
          p1dot_nxt       = 1'b0;
          state_nxt       = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    out_ch.valid    = out_valid_r;
    out_ch.matched  = out_matched_r;
    out_ch.too_long = out_toolong_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      plen_r      <= '0;
      hlen_r      <= '0;
      pnum_r      <= 1'b1;
      hnum_r      <= 1'b1;
      dots_r      <= '0;
      ovf_r       <= 1'b0;
      p0star_r    <= 1'b0;
      p1dot_r     <= 1'b0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      mismatch_r  <= 1'b0;
      toolong_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      hlen_r      <= hlen_nxt;
      pnum_r      <= pnum_nxt;
      hnum_r      <= hnum_nxt;
      dots_r      <= dots_nxt;
      ovf_r       <= ovf_nxt;
      p0star_r    <= p0star_nxt;
      p1dot_r     <= p1dot_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      mismatch_r  <= mismatch_nxt;
      toolong_r   <= toolong_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ps_r          <= ps_nxt;
    hs_r          <= hs_nxt;
    n_r           <= n_nxt;
    out_matched_r <= out_matched_nxt;
    out_toolong_r <= out_toolong_nxt;
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pop_entry.ch;
    end
    if (rd_en) begin
      pat_rd_r <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (host_we) begin
      host_mem[host_waddr] <= pop_entry.ch;
    end
    if (rd_en) begin
      host_rd_r <= host_mem[host_raddr];
    end
  end

endmodule

// ===== rtl/core/cert_hostname_wildcard_match_unit.sv =====
// Top level of the certificate hostname wildcard matcher; requests are stored one per cycle
// while the back end is loading, and the queue holds off the input once it is full.
// The result passes from the hostname's final request through the queue, the decide, compare
// and finish states and the output register, skipping the compare state when the decision
// needs none; compare reads one character pair per cycle via each store's single read port.
// rst_n is synchronous and active low; it empties the queue and resets the string lengths and state flags.
module cert_hostname_wildcard_match_unit (
  input  logic       clk,
  input  logic       rst_n,
  chwm_in_if.sink    in_ch,
  chwm_out_if.source out_ch
);
  import chwm_pkg::*;

  // The front end classifies each request: it folds upper-case letters to lower case and
  // marks digits, dots and the star, so that the back end needs only flag updates.
  logic        push_valid, push_ready;
  chwm_entry_t push_entry;

  // The queue lets the front end take up to two requests while the back end is busy with
  // the comparison of the previous pair.
  logic        pop_valid, pop_ready;
  chwm_entry_t pop_entry;

  chwm_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  chwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // The back end writes the two stores, decides between the wildcard and the plain path,
  // walks the character pairs and places the result in an output register, after which
  // its lengths and load flags return to the reset values for the next pair of strings.
  chwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/chwm_checker.sv =====
// Port-level checks on the result channel of the matcher, bound to the top level.
module chwm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched,
  input logic out_too_long
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_matched) && $stable(out_too_long)))
    else $error("result payload changed while stalled");

  a_toolong_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_too_long) |-> !out_matched)
    else $error("overlong result reports a match");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cert_hostname_wildcard_match_unit chwm_checker u_chwm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_matched  (out_ch.matched),
  .out_too_long (out_ch.too_long)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the certificate hostname wildcard matcher.
module testbench;
  import chwm_pkg::*;

  // Run shape. The idle limit covers the longest compare pass,
  // the longest random stall on either side and the deliberate hold-off.
  localparam int REQ_TARGET   = 950;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_AFTER   = 12;
  localparam int HOLD_CYCLES  = 700;
  localparam int DRAIN_CYCLES = MAX_LEN + 16;
  localparam int REPORT_MAX   = 10;

  // One request as the bench sees it, and the verdict that a hostname's end
  // produces.
  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              none;
  } req_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } verdict_t;

  // A row of the directed table. Where typed is set, the verdict in the row is
  // the one expected; otherwise the bench's own matcher supplies it.
  typedef struct packed {
    req_t     req;
    logic     typed;
    verdict_t verdict;
  } row_t;

  localparam int DIR_ROWS = 24;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // Empty pattern against an empty hostname: never a match.
    '{'{ACT_HOST,    8'h00, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    // The end mark on a pattern request changes nothing, an empty request
    // stores nothing, and a zero byte is an ordinary character. Case folds.
    '{'{ACT_PATTERN, "A",   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, 8'hFF, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, 8'h00, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "a",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    8'h00, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    // Star pattern with two dots after the star: tail comparison.
    '{'{ACT_PATTERN, "*",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, "b",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, "C",   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "x",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "B",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "c",   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    // Digits-and-dots text on both sides keeps the wildcard path shut.
    '{'{ACT_PATTERN, "*",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_PATTERN, "7",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "9",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    ".",   1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    "7",   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    // Top byte value on both sides is an exact match.
    '{'{ACT_PATTERN, 8'hFF, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{ACT_HOST,    8'hFF, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0}}
  };

  logic clk;
  logic rst_n;

  chwm_in_if  in_ch ();
  chwm_out_if out_ch ();

  cert_hostname_wildcard_match_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // The bench's own matcher: a copy of the pair state, updated as each request
  // is accepted.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] pat_mem  [MAX_LEN];
  logic [CHAR_W-1:0] host_mem [MAX_LEN];
  int                pat_len;
  int                host_len;
  logic [1:0]        pat_dots;
  bit                pat_numeric;
  bit                host_numeric;
  bit                len_overflow;

  verdict_t verdict_q [$];
  req_t     stim_q [$];

  int  reqs_sent;
  int  pairs_done;
  int  matches_predicted;
  int  overlong_pairs;
  int  wildcard_paths;
  int  results_seen;
  int  mismatches;
  bit  send_calm;
  bit  rx_calm;

  function automatic bit is_num_char(input logic [CHAR_W-1:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
  endfunction

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? (c | 8'h20) : c;
  endfunction

  function automatic void clear_pair();
    pat_len      = 0;
    host_len     = 0;
    pat_dots     = 2'd0;
    pat_numeric  = 1'b1;
    host_numeric = 1'b1;
    len_overflow = 1'b0;
  endfunction

  // Decides whether the stored hostname matches the stored pattern. On the
  // wildcard path the star is skipped and, where the rest carries at least two
  // dots, only the hostname's tail of the same length is compared.
  function automatic bit names_agree();
    int ps;
    int hs;
    int n;
    ps = 0;
    hs = 0;
    if (pat_len == 0) return 1'b0;
    if (!pat_numeric && !host_numeric && (pat_len >= 2) &&
        (pat_mem[0] == CH_STAR) && (pat_mem[1] == CH_DOT)) begin
      ps = 1;
      wildcard_paths++;
      if ((pat_dots >= DOT_SAT) && (host_len > pat_len - 1))
        hs = host_len - (pat_len - 1);
    end
    n = pat_len - ps;
    if (n != host_len - hs) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (lower_ascii(pat_mem[ps + i]) != lower_ascii(host_mem[hs + i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one accepted request; returns 1 with the verdict when the request
  // closes a hostname.
  function automatic bit take_request(input req_t r, output verdict_t v);
    v = '0;
    if (!r.none) begin
      if (r.action == ACT_PATTERN) begin
        if (pat_len >= MAX_LEN) begin
          len_overflow = 1'b1;
        end else begin
          // A star in the first place does not count against the digits test.
          if (!((pat_len == 0) && (r.ch == CH_STAR)) && !is_num_char(r.ch))
            pat_numeric = 1'b0;
          if ((pat_len >= 1) && (r.ch == CH_DOT) && (pat_dots < DOT_SAT))
            pat_dots++;
          pat_mem[pat_len] = r.ch;
          pat_len++;
        end
      end else begin
        if (host_len >= MAX_LEN) begin
          len_overflow = 1'b1;
        end else begin
          if (!is_num_char(r.ch)) host_numeric = 1'b0;
          host_mem[host_len] = r.ch;
          host_len++;
        end
      end
    end
    if ((r.action == ACT_HOST) && r.last) begin
      v.too_long = len_overflow;
      v.matched  = len_overflow ? 1'b0 : names_agree();
      pairs_done++;
      if (v.matched)  matches_predicted++;
      if (v.too_long) overlong_pairs++;
      clear_pair();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus helpers.
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit numeric);
    int r;
    r = $urandom_range(0, 99);
    if (numeric) return (r < 25) ? CH_DOT : CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 55) return CH_UC_A + 8'($urandom_range(0, 25));
    if (r < 70) return CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 85) return CH_DOT;
    if (r < 90) return 8'h2D;
    return 8'($urandom_range(0, 255));
  endfunction

  // Swaps the case of letters at random, so that matching names differ in case.
  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
    bit letter;
    letter = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= 8'h61) && (c <= 8'h7A));
    return (letter && $urandom_range(0, 1)) ? (c ^ 8'h20) : c;
  endfunction

  function automatic req_t mk_req(input logic action, input logic [CHAR_W-1:0] ch,
                                  input logic last, input logic none);
    req_t r;
    r.action = action;
    r.ch     = ch;
    r.last   = last;
    r.none   = none;
    return r;
  endfunction

  // Builds one pattern and hostname pair and queues its requests. Most pairs
  // are well formed with a pattern derived from the hostname, so that exact,
  // wildcard and tail matches happen often; the rest are corrupted copies,
  // random text, empty or overlong strings, empty requests and stray pattern
  // bytes arriving while the hostname is already streaming.
  task automatic build_pair();
    logic [CHAR_W-1:0] host_s [$];
    logic [CHAR_W-1:0] pat_s [$];
    int  hlen;
    int  plen;
    int  k;
    int  dot_at;
    bit  numeric;
    bit  trail_empty;
    bit  end_here;
    k = $urandom_range(0, 99);
    if (k < 2)      hlen = 0;
    else if (k < 4) hlen = $urandom_range(200, MAX_LEN);
    else if (k < 5) hlen = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
    else            hlen = $urandom_range(1, 14);
    numeric = ($urandom_range(0, 9) == 0);
    repeat (hlen) host_s.push_back(pick_char(numeric));

    k = $urandom_range(0, 99);
    if (k < 25) begin
      foreach (host_s[i]) pat_s.push_back(flip_case(host_s[i]));
    end else if (k < 55) begin
      // Star followed by the hostname from its first dot onwards.
      dot_at = -1;
      foreach (host_s[i]) if ((dot_at < 0) && (host_s[i] == CH_DOT)) dot_at = i;
      pat_s.push_back(CH_STAR);
      if (dot_at < 0) begin
        pat_s.push_back(CH_DOT);
        repeat ($urandom_range(1, 6)) pat_s.push_back(pick_char(1'b0));
      end else begin
        for (int i = dot_at; i < host_s.size(); i++) pat_s.push_back(flip_case(host_s[i]));
      end
    end else if (k < 75) begin
      foreach (host_s[i]) pat_s.push_back(host_s[i]);
      if ((pat_s.size() > 0) && (k < 65))
        pat_s[$urandom_range(0, pat_s.size() - 1)] = 8'($urandom_range(0, 255));
      else if ((pat_s.size() > 0) && (k < 70))
        void'(pat_s.pop_back());
      else
        pat_s.push_back(pick_char(1'b0));
    end else if (k < 85) begin
      if ($urandom_range(0, 2) == 0) begin
        pat_s.push_back(CH_STAR);
        pat_s.push_back(CH_DOT);
      end
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_LEN - 1, MAX_LEN + 3)
                                           : $urandom_range(1, 8);
      repeat (plen) pat_s.push_back(pick_char(1'b0));
    end else if (k < 92) begin
      if (k < 89) begin
        pat_s.push_back(CH_STAR);
        pat_s.push_back(CH_DOT);
      end
      repeat ($urandom_range(1, 6)) pat_s.push_back(pick_char(1'b1));
    end
    // Otherwise the pattern stays empty.

    foreach (pat_s[i]) begin
      if ($urandom_range(0, 14) == 0)
        stim_q.push_back(mk_req(ACT_PATTERN, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 1'b1));
      stim_q.push_back(mk_req(ACT_PATTERN, pat_s[i],
                              (i == pat_s.size() - 1) ? 1'($urandom_range(0, 1))
                                                      : ($urandom_range(0, 19) == 0),
                              1'b0));
    end

    trail_empty = (host_s.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (host_s[i]) begin
      if ($urandom_range(0, 29) == 0)
        stim_q.push_back(mk_req(ACT_PATTERN, pick_char(1'b0), 1'b0, 1'b0));
      if ($urandom_range(0, 14) == 0)
        stim_q.push_back(mk_req(ACT_HOST, 8'($urandom_range(0, 255)), 1'b0, 1'b1));
      end_here = (i == host_s.size() - 1) && !trail_empty;
      stim_q.push_back(mk_req(ACT_HOST, host_s[i], end_here, 1'b0));
    end
    // The hostname may also be closed by an empty request.
    if (trail_empty)
      stim_q.push_back(mk_req(ACT_HOST, 8'($urandom_range(0, 255)), 1'b1, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a request is taken at the
  // rising edge that sees valid and ready together, and only then is it fed to
  // the bench's matcher.
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_t r, input logic typed, input verdict_t typed_v);
    int       gap;
    verdict_t v;
    gap = 0;
    if ($urandom_range(0, 299) == 0) send_calm = !send_calm;
    if (!send_calm && ($urandom_range(0, 99) < 30)) gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= r.action;
    in_ch.char_code <= r.ch;
    in_ch.last_char <= r.last;
    in_ch.no_char   <= r.none;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reqs_sent++;
    if (take_request(r, v)) verdict_q.push_back(typed ? typed_v : v);
  endtask

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at %0t ns: %s", $time, msg);
  endfunction

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_PATTERN;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    in_ch.no_char   = 1'b0;
    rst_n           = 1'b0;
    reqs_sent         = 0;
    pairs_done        = 0;
    matches_predicted = 0;
    overlong_pairs    = 0;
    wildcard_paths    = 0;
    mismatches        = 0;
    send_calm         = 1'b0;
    clear_pair();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].verdict);

    // The random part runs whole pairs until enough requests have been taken.
    while (reqs_sent < REQ_TARGET) begin
      build_pair();
      while (stim_q.size() > 0) send_req(stim_q.pop_front(), 1'b0, '0);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // The watchdog bounds this wait; the tail then catches any spurious result.
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d name pairs: %0d matches, %0d overlong,",
             reqs_sent, pairs_done, matches_predicted, overlong_pairs);
    $display("%0d wildcard decisions, %0d results checked, %0d mismatches.",
             wildcard_paths, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. Ready changes on the falling edge with random stalls and calm
  // stretches. Once, after a dozen results, the receiver holds off for a long
  // stretch while requests keep coming, so that the block fills up and has to
  // push back on its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left   = 0;
    hold_done    = 1'b0;
    rx_calm      = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 255) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!hold_done && (results_seen >= HOLD_AFTER)) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (!rx_calm && ($urandom_range(0, 99) < 20)) begin
        stall_left = pick_gap();
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Each accepted result is checked, field by field, against the oldest
  // verdict still waiting.
  initial results_seen = 0;

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result, matched=%0b too_long=%0b",
                                out_ch.matched, out_ch.too_long));
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.matched !== want.matched)
          note_mismatch($sformatf("matched: expected %0b, got %0b",
                                  want.matched, out_ch.matched));
        if (out_ch.too_long !== want.too_long)
          note_mismatch($sformatf("too_long: expected %0b, got %0b",
                                  want.too_long, out_ch.too_long));
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, verdict_q.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

endmodule
